>>> hdl/rbs_pkg.sv
// Shared types and constants of the radial brush stamp.
`timescale 1ns / 1ps
package rbs_pkg;

	// Operation codes carried by the mode field
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_ADD   = 2'd2;
	localparam logic [1:0] MODE_SUB   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;
	localparam logic [1:0] REG_STRENGTH = 2'd3;

	localparam int unsigned Q15_ONE      = 32768;
	localparam int unsigned STRENGTH_MAX = 131072;
	localparam int unsigned COUNT_MAX    = 16383;

	// Signed width of a visited cell coordinate: centre plus or minus the radius
	localparam int COORD_W = 12;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_SCAN,
		ST_SQRT,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_FIN
	} rbs_state_t;

endpackage

>>> hdl/rbs_isqrt.sv
// Digit-by-digit square root of a squared distance scaled by 2^30, two bits a cycle.
`timescale 1ns / 1ps
module rbs_isqrt #(
	parameter int D2W = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [D2W-1:0]         d2,
	output logic                   done,
	output logic [D2W/2+14:0]      root
);
	localparam int SW   = D2W + 30;
	localparam int QW   = SW / 2;
	localparam int RMW  = QW + 3;
	localparam int CNTW = $clog2(QW + 1);

	logic [SW-1:0]   rad_q;
	logic [RMW-1:0]  rem_q;
	logic [QW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [RMW-1:0] rem_sh;
	logic [RMW-1:0] trial;
	logic           fits;

	assign rem_sh = {rem_q[RMW-3:0], rad_q[SW-1 -: 2]};
	assign trial  = RMW'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {d2, 30'b0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/rbs_div.sv
// Restoring divider of the scaled distance by the radius, one quotient bit a cycle.
`timescale 1ns / 1ps
module rbs_div #(
	parameter int DW = 21,
	parameter int RW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [RW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   dvd_q;
	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [RW:0] rem_sh;
	logic [RW:0] diff;
	logic        ge;

	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

>>> hdl/radial_brush_stamp.sv
// Top level of the radial brush stamp: control sequencer, field memory and update path.
`timescale 1ns / 1ps
// The block keeps a MAX_WIDTH by MAX_HEIGHT field of Q15 cells in one synchronous
// memory. After reset a clearing pass writes zero to every cell, one a cycle; no
// item is taken meanwhile, though configuration writes are. A cell read or write
// passes through the cell and finish states before its result is registered for
// the output. A stamp scans the (2r+1)^2 cells of its square, one a cycle, and every
// cell that lies inside the field and the disc holds the scan while it passes the
// two-bits-a-cycle square root unit and the bit-serial divider that the cells share,
// then the multiply and update states. One item is worked on at a time; the next
// one is taken while the result still waits in the output register.
module radial_brush_stamp
	import rbs_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 63
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [9:0]  pos_x,
	input  logic signed [9:0]  pos_y,
	input  logic [15:0]        write_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        read_value,
	output logic               status,
	output logic [13:0]        cells_changed
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int D2W   = 2 * RW;
	localparam int QW    = RW + 15;
	localparam int CW    = COORD_W;

	// Configuration registers keep the bits written; saturation happens at use
	logic [8:0]  cfg_w_q;
	logic [8:0]  cfg_h_q;
	logic [5:0]  cfg_r_q;
	logic [17:0] cfg_s_q;

	rbs_state_t state_q, state_d;

	logic [1:0]           mode_q;
	logic signed [9:0]    px_q;
	logic signed [9:0]    py_q;
	logic [15:0]          wv_q;
	logic [WW-1:0]        fw_q;
	logic [HW-1:0]        fh_q;
	logic [RW-1:0]        r_q;
	logic [D2W-1:0]       r2_q;
	logic [17:0]          s_q;
	logic signed [CW-1:0] i_q;
	logic signed [CW-1:0] j_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        clr_q;
	logic [13:0]          cnt_q;
	logic                 err_q;
	logic [33:0]          prod_s1;

	logic        out_valid_q;
	logic [15:0] out_rd_q;
	logic        out_st_q;
	logic [13:0] out_cnt_q;

	logic [15:0] mem [DEPTH];
	logic [15:0] mem_rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [15:0] mem_wdata;

	// Saturated views of the configuration
	logic [WW-1:0] fw_sel;
	logic [HW-1:0] fh_sel;
	logic [RW-1:0] r_sel;
	logic [17:0]   s_sel;

	logic in_acc, out_free, out_load, sq_start, dv_start, sq_done, dv_done;
	logic [QW-1:0] sq_root;
	logic [QW-1:0] dv_quot;

	// Cell read or write addressing
	logic signed [CW-1:0] pxe, pye;
	logic                 pt_inside;
	logic [AW-1:0]        pt_addr;

	// Stamp scan
	logic signed [CW-1:0] fx, fy, r_s;
	logic [CW-1:0]        ai, aj;
	logic [D2W-1:0]       ai_sq, aj_sq;
	logic [D2W:0]         d2;
	logic                 cell_in, hit, scan_last;
	logic [AW-1:0]        cell_addr;

	// Update
	logic [15:0] falloff;
	logic [18:0] delta;
	logic [19:0] sum;
	logic [15:0] upd_val;
	logic [15:0] wv_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 9'd256;
			cfg_h_q <= 9'd256;
			cfg_r_q <= 6'd8;
			cfg_s_q <= 18'd3277;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:    cfg_w_q <= cfg_data[8:0];
				REG_HEIGHT:   cfg_h_q <= cfg_data[8:0];
				REG_RADIUS:   cfg_r_q <= cfg_data[5:0];
				REG_STRENGTH: cfg_s_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_w_q == 9'd0) fw_sel = WW'(1);
		else if (CW'(cfg_w_q) > CW'(MAX_WIDTH)) fw_sel = WW'(MAX_WIDTH);
		else fw_sel = WW'(cfg_w_q);
		if (cfg_h_q == 9'd0) fh_sel = HW'(1);
		else if (CW'(cfg_h_q) > CW'(MAX_HEIGHT)) fh_sel = HW'(MAX_HEIGHT);
		else fh_sel = HW'(cfg_h_q);
		if (cfg_r_q == 6'd0) r_sel = RW'(1);
		else if (CW'(cfg_r_q) > CW'(MAX_RADIUS)) r_sel = RW'(MAX_RADIUS);
		else r_sel = RW'(cfg_r_q);
		s_sel = (cfg_s_q > 18'(STRENGTH_MAX)) ? 18'(STRENGTH_MAX) : cfg_s_q;
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Single cell addressing
	assign pxe       = CW'(px_q);
	assign pye       = CW'(py_q);
	assign pt_inside = !pxe[CW-1] && !pye[CW-1] && (pxe < signed'(CW'(fw_q)))
		&& (pye < signed'(CW'(fh_q)));
	assign pt_addr   = AW'(pye) * AW'(MAX_WIDTH) + AW'(pxe);

	// Stamp cell under the scan pointer
	assign r_s       = signed'(CW'(r_q));
	assign fx        = pxe + i_q;
	assign fy        = pye + j_q;
	assign ai        = i_q[CW-1] ? CW'(-i_q) : CW'(i_q);
	assign aj        = j_q[CW-1] ? CW'(-j_q) : CW'(j_q);
	assign ai_sq     = ai[RW-1:0] * ai[RW-1:0];
	assign aj_sq     = aj[RW-1:0] * aj[RW-1:0];
	assign d2        = {1'b0, ai_sq} + {1'b0, aj_sq};
	assign cell_in   = !fx[CW-1] && !fy[CW-1] && (fx < signed'(CW'(fw_q)))
		&& (fy < signed'(CW'(fh_q)));
	assign hit       = cell_in && (d2 <= {1'b0, r2_q});
	assign scan_last = (i_q == r_s) && (j_q == r_s);
	assign cell_addr = AW'(fy) * AW'(MAX_WIDTH) + AW'(fx);

	// Falloff and clamped update of the cell
	assign falloff = (dv_quot >= QW'(Q15_ONE)) ? 16'd0 : 16'(QW'(Q15_ONE) - dv_quot);
	assign delta   = prod_s1[33:15];
	assign sum     = 20'(mem_rdata_q) + 20'(delta);
	always_comb begin
		if (mode_q == MODE_ADD) begin
			upd_val = (sum > 20'(Q15_ONE)) ? 16'(Q15_ONE) : sum[15:0];
		end else begin
			upd_val = (19'(mem_rdata_q) <= delta) ? 16'd0 : 16'(19'(mem_rdata_q) - delta);
		end
	end
	assign wv_sat = (wv_q > 16'(Q15_ONE)) ? 16'(Q15_ONE) : wv_q;

	rbs_isqrt #(
		.D2W(D2W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.d2    (d2[D2W-1:0]),
		.done  (sq_done),
		.root  (sq_root)
	);

	rbs_div #(
		.DW(QW),
		.RW(RW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.dividend(sq_root),
		.divisor (r_q),
		.done    (dv_done),
		.quotient(dv_quot)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) state_d = (mode inside {MODE_READ, MODE_WRITE}) ? ST_CELL : ST_SCAN;
			end
			ST_CELL: state_d = ST_FIN;
			ST_SCAN: begin
				if (hit) state_d = ST_SQRT;
				else if (scan_last) state_d = ST_FIN;
			end
			ST_SQRT: if (sq_done) state_d = ST_DIV;
			ST_DIV:  if (dv_done) state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD:  state_d = scan_last ? ST_FIN : ST_SCAN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		sq_start  = (state_q == ST_SCAN) && hit;
		dv_start  = (state_q == ST_SQRT) && sq_done;
		out_load  = (state_q == ST_FIN) && out_free;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = upd_val;
		mem_raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 16'd0;
			end
			ST_CELL: begin
				mem_raddr = pt_addr;
				mem_waddr = pt_addr;
				mem_wdata = wv_sat;
				mem_we    = pt_inside && (mode_q == MODE_WRITE);
			end
			// The read of a cell must hold while the result waits for the output register.
			ST_FIN: mem_raddr = pt_addr;
			ST_UPD: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			px_q   <= pos_x;
			py_q   <= pos_y;
			wv_q   <= write_value;
			fw_q   <= fw_sel;
			fh_q   <= fh_sel;
			r_q    <= r_sel;
			r2_q   <= r_sel * r_sel;
			s_q    <= s_sel;
			i_q    <= '0 - signed'(CW'(r_sel));
			j_q    <= '0 - signed'(CW'(r_sel));
			cnt_q  <= '0;
			err_q  <= 1'b0;
		end
		if (state_q == ST_CELL) err_q <= !pt_inside;
		if (state_q == ST_SCAN && hit) addr_q <= cell_addr;
		if (state_q == ST_MUL) prod_s1 <= s_q * falloff;
		if (state_q == ST_UPD && cnt_q != 14'(COUNT_MAX)) cnt_q <= cnt_q + 14'd1;
		if ((state_q == ST_SCAN && !hit) || state_q == ST_UPD) begin
			if (i_q == r_s) begin
				i_q <= -r_s;
				j_q <= j_q + CW'(1);
			end else begin
				i_q <= i_q + CW'(1);
			end
		end
		if (out_load) begin
			out_rd_q  <= (mode_q == MODE_READ && !err_q) ? mem_rdata_q : 16'd0;
			out_st_q  <= err_q;
			out_cnt_q <= cnt_q;
		end
	end

	// Field memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	assign out_valid     = out_valid_q;
	assign read_value    = out_rd_q;
	assign status        = out_st_q;
	assign cells_changed = out_cnt_q;

	a_mem_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_CELL || state_q == ST_UPD))
		else $error("field memory written outside a write phase");

	a_wdata_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_wdata <= 16'(Q15_ONE)))
		else $error("cell value above one written");

	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_SQRT))
		else $error("square root finished outside its wait state");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == ST_DIV))
		else $error("division finished outside its wait state");

	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (cells_changed == 14'd0))
		else $error("error beat carries a cell count");

endmodule
